// ===== rtl/pba_pkg.sv =====
// Shared constants, codes and types of the page bitmap allocator.
package pba_pkg;

	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 23;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_MASK  = 4095;
	localparam int WORD_BITS  = 8;
	localparam int WB_W       = 3;
	// page numbers: (32 - 12) bits plus one for counts up to 2^20
	localparam int PG_W       = ADDR_W - PAGE_SHIFT + 1;
	// page count of one request: ceil of a 23-bit length over 4096
	localparam int NPG_W      = LEN_W + 1 - PAGE_SHIFT;

	localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'd4194304;

	// configuration register indexes
	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	// opcodes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OOM      = 2'd1;
	localparam logic [1:0] ST_LIMIT    = 2'd2;
	localparam logic [1:0] ST_NOTALLOC = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_PLACE,
		S_SETUP,
		S_SEARCH,
		S_FOUND,
		S_RANGE,
		S_RESP
	} state_t;

	// per-word first-fit scan result
	typedef struct packed {
		logic            found;
		logic [PG_W-1:0] hit_pg;
		logic [PG_W-1:0] run;
	} scan_res_t;

endpackage

// ===== rtl/page_bitmap_allocator.sv =====
// Page bitmap allocator: one used bit per 4 KiB page, first-fit search.
//
// Input channel: in_valid/in_stall carry one request item (opcode, address,
// length); the item is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall carry one result item per request
// (result_address, status), held stable while out_stall is high.
// Configuration: cfg_we writes cfg_data to region_base (index 0) or
// region_limit (index 1); write only while no request is in flight.
// One request is worked at a time. The bitmap sits in a memory of 8-bit
// words with a registered read; scans and read-modify-write passes move one
// word per cycle. A mark, free or check runs a range pass, and an allocate
// by search runs a search pass and then a mark pass. The memory port
// sets the rate: one word read and one written per cycle.
// Reset: a clearing pass writes every word to zero, during which in_stall
// stays high.
// A finished result waits in the result register while the output slot is
// held; no next request is taken until it moves to the output slot.
module page_bitmap_allocator #(
	parameter int NUM_PAGES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [pba_pkg::ADDR_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic [pba_pkg::ADDR_W-1:0] address,
	input  logic [pba_pkg::LEN_W-1:0]  length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pba_pkg::ADDR_W-1:0] result_address,
	output logic [1:0]                 status
);
	import pba_pkg::*;

	localparam int ROWS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int RA_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [PG_W-1:0] NUM_PG   = PG_W'(NUM_PAGES);
	localparam logic [RA_W-1:0] LAST_ROW = RA_W'(ROWS - 1);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]    base_q, limit_q;
	logic [PG_W-1:0]      cnt_q;
	logic [1:0]           op_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [LEN_W-1:0]     len_q;
	logic [NPG_W-1:0]     npg_q;
	logic [PG_W-1:0]      lo_pg_q;
	logic [RA_W-1:0]      lo_w_q, last_w_q, issue_q, wrd_s1, clr_q;
	logic [WB_W-1:0]      lo_b_q, hi_b_q;
	logic                 iss_more_q, vld_s1;
	logic [PG_W-1:0]      run_q, hit_q;
	logic [ADDR_W-1:0]    res_addr_q, out_addr_q;
	logic [1:0]           res_st_q, out_st_q;
	logic                 out_valid_q;

	logic [WORD_BITS-1:0] mem [ROWS];
	logic [WORD_BITS-1:0] rdata_s1;

	logic [ADDR_W-1:0]    diff, off, found_addr;
	logic [PG_W-1:0]      cnt_full, cnt_d, start_pg, cnt_last;
	logic [PG_W-1:0]      rng_end, rng_last, hi_pg, sp, pg0;
	logic [LEN_W:0]       len_sum;
	logic [NPG_W-1:0]     npg_in;
	logic [ADDR_W:0]      end_sum;
	logic                 lim_over, below_base, is_search, is_check, scanning;
	logic                 slot_free;
	logic [WORD_BITS-1:0] page_mask, wr_data;
	logic                 wr_en;
	logic [RA_W-1:0]      wr_addr;
	logic                 fin;
	logic [ADDR_W-1:0]    fin_addr;
	logic [1:0]           fin_st;
	scan_res_t            scan;

	// region page count, capped at the store size
	assign diff     = limit_q - base_q;
	assign cnt_full = PG_W'(diff[ADDR_W-1:PAGE_SHIFT]) + PG_W'(|diff[PAGE_SHIFT-1:0]);
	assign cnt_d    = (cnt_full > NUM_PG) ? NUM_PG : cnt_full;
	assign cnt_last = cnt_q - PG_W'(1);

	// request length in whole pages
	assign len_sum = {1'b0, length} + (LEN_W + 1)'(PAGE_MASK);
	assign npg_in  = len_sum[LEN_W:PAGE_SHIFT];

	// limit and base tests, start page of the range
	assign end_sum    = {1'b0, addr_q} + (ADDR_W + 1)'(len_q);
	assign lim_over   = end_sum > {1'b0, limit_q};
	assign below_base = addr_q < base_q;
	assign off        = addr_q - base_q;
	assign start_pg   = PG_W'(off[ADDR_W-1:PAGE_SHIFT]);
	assign is_search  = (op_q == OP_ALLOC) && (addr_q == '0);
	assign is_check   = (op_q == OP_CHECK);

	// last page of the range, clipped to the store
	assign rng_end  = lo_pg_q + PG_W'(npg_q);
	assign rng_last = rng_end - PG_W'(1);
	assign hi_pg    = (rng_last > NUM_PG - PG_W'(1)) ? (NUM_PG - PG_W'(1)) : rng_last;

	// start address of a found run
	assign sp         = hit_q - PG_W'(npg_q) + PG_W'(1);
	assign found_addr = base_q + (ADDR_W'(sp) << PAGE_SHIFT);

	assign scanning  = (state_q == S_SEARCH) || (state_q == S_RANGE);
	assign slot_free = !out_valid_q || !out_stall;

	// pages of the word in flight that fall inside the range
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			page_mask[j] = ((wrd_s1 != lo_w_q) || (WB_W'(j) >= lo_b_q)) &&
				((wrd_s1 != last_w_q) || (WB_W'(j) <= hi_b_q));
		end
	end

	// search one word per cycle
	assign pg0 = PG_W'(wrd_s1) << WB_W;

	pba_run_scan u_scan (
		.word   (rdata_s1),
		.pg0    (pg0),
		.cnt    (cnt_q),
		.run_in (run_q),
		.req    (npg_q),
		.res    (scan)
	);

	// write port: clearing pass or range update of the word just read
	assign wr_en   = (state_q == S_CLEAR) || ((state_q == S_RANGE) && vld_s1 && !is_check);
	assign wr_addr = (state_q == S_CLEAR) ? clr_q : wrd_s1;
	assign wr_data = (state_q == S_CLEAR) ? '0 :
		((op_q == OP_ALLOC) ? (rdata_s1 | page_mask) : (rdata_s1 & ~page_mask));

	// bitmap memory; a pass reads word k+1 while writing word k, never the same
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[issue_q];
	end

	// next state and finish decisions
	always_comb begin
		state_d  = state_q;
		fin      = 1'b0;
		fin_addr = '0;
		fin_st   = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_ROW) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_PREP;
			end
			S_PREP: begin
				case (op_q) inside
					OP_ALLOC, OP_FREE: begin
						if (is_search) begin
							if (cnt_q <= PG_W'(1)) begin
								fin    = 1'b1;
								fin_st = ST_OOM;
							end else if (npg_q == '0) begin
								state_d = S_FOUND;
							end else begin
								state_d = S_SEARCH;
							end
						end else begin
							state_d = S_PLACE;
						end
					end
					OP_CHECK: begin
						if (below_base || lim_over) begin
							fin    = 1'b1;
							fin_st = ST_NOTALLOC;
						end else begin
							state_d = S_SETUP;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_PLACE: begin
				if (lim_over) begin
					fin    = 1'b1;
					fin_st = ST_LIMIT;
				end else begin
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				if (npg_q == '0) begin
					fin      = 1'b1;
					fin_addr = addr_q;
				end else if (is_check) begin
					if (rng_end > NUM_PG) begin
						fin    = 1'b1;
						fin_st = ST_NOTALLOC;
					end else begin
						state_d = S_RANGE;
					end
				end else if (lo_pg_q >= NUM_PG) begin
					fin      = 1'b1;
					fin_addr = addr_q;
				end else begin
					state_d = S_RANGE;
				end
			end
			S_SEARCH: begin
				if (vld_s1) begin
					if (scan.found) begin
						state_d = S_FOUND;
					end else if (wrd_s1 == last_w_q) begin
						fin    = 1'b1;
						fin_st = ST_OOM;
					end
				end
			end
			S_FOUND: begin
				state_d = S_PLACE;
			end
			S_RANGE: begin
				if (vld_s1) begin
					if (is_check && ((rdata_s1 & page_mask) != page_mask)) begin
						fin    = 1'b1;
						fin_st = ST_NOTALLOC;
					end else if (wrd_s1 == last_w_q) begin
						fin      = 1'b1;
						fin_addr = addr_q;
					end
				end
			end
			S_RESP: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) state_d = S_RESP;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: configuration, pass counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			limit_q     <= LIMIT_RESET;
			cnt_q       <= '0;
			clr_q       <= '0;
			vld_s1      <= 1'b0;
			iss_more_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BASE:  base_q  <= cfg_data;
					CFG_LIMIT: limit_q <= cfg_data;
				endcase
			end
			cnt_q <= cnt_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + RA_W'(1);
			// advance the read pointer; stop after the last word
			if (scanning && iss_more_q) begin
				vld_s1     <= 1'b1;
				iss_more_q <= (issue_q != last_w_q);
			end else begin
				vld_s1 <= 1'b0;
			end
			if ((state_q == S_PREP) || (state_q == S_SETUP)) iss_more_q <= 1'b1;
			// load the output slot, drop it once taken
			if ((state_q == S_RESP) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and pass payload
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			op_q   <= opcode;
			addr_q <= address;
			len_q  <= length;
			npg_q  <= npg_in;
		end
		if (state_q == S_PREP) begin
			issue_q  <= '0;
			last_w_q <= cnt_last[RA_W+WB_W-1:WB_W];
			run_q    <= '0;
			hit_q    <= '0;
		end
		if ((state_q == S_PREP) || (state_q == S_PLACE)) lo_pg_q <= start_pg;
		if (state_q == S_SETUP) begin
			lo_w_q   <= lo_pg_q[RA_W+WB_W-1:WB_W];
			lo_b_q   <= lo_pg_q[WB_W-1:0];
			last_w_q <= hi_pg[RA_W+WB_W-1:WB_W];
			hi_b_q   <= hi_pg[WB_W-1:0];
			issue_q  <= lo_pg_q[RA_W+WB_W-1:WB_W];
		end
		if (scanning && iss_more_q) begin
			issue_q <= issue_q + RA_W'(1);
			wrd_s1  <= issue_q;
		end
		if ((state_q == S_SEARCH) && vld_s1) begin
			run_q <= scan.run;
			if (scan.found) hit_q <= scan.hit_pg;
		end
		if (state_q == S_FOUND) addr_q <= found_addr;
		if (fin) begin
			res_addr_q <= fin_addr;
			res_st_q   <= fin_st;
		end
		if ((state_q == S_RESP) && slot_free) begin
			out_addr_q <= res_addr_q;
			out_st_q   <= res_st_q;
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_st_q;

	// a range pass stays inside its word bounds
	ap_range_words: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RANGE) && vld_s1 |-> (wrd_s1 >= lo_w_q) && (wrd_s1 <= last_w_q))
		else $error("range pass left its word bounds");

	// a found run ends inside the searchable pages
	ap_hit_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) && vld_s1 && scan.found |->
			(scan.hit_pg != '0) && (scan.hit_pg < cnt_q))
		else $error("search hit outside the region");

	// a finished result waits while the output slot is held
	ap_resp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) && out_valid_q && out_stall |=> (state_q == S_RESP))
		else $error("result dropped while output stalled");

	// a stalled result stays valid and unchanged outside S_RESP
	ap_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && (state_q != S_RESP) |=> out_valid_q && $stable(out_addr_q))
		else $error("stalled result changed");

endmodule

// ===== rtl/pba_run_scan.sv =====
// First-fit run scan over one bitmap word.
module pba_run_scan (
	input  logic [pba_pkg::WORD_BITS-1:0] word,
	input  logic [pba_pkg::PG_W-1:0]      pg0,
	input  logic [pba_pkg::PG_W-1:0]      cnt,
	input  logic [pba_pkg::PG_W-1:0]      run_in,
	input  logic [pba_pkg::NPG_W-1:0]     req,
	output pba_pkg::scan_res_t            res
);
	import pba_pkg::*;

	// walk the word's pages; page 0 and pages past the region count as used
	always_comb begin
		logic [PG_W-1:0] pg;
		logic            used;
		logic            all_free;
		logic [WB_W:0]   tail;
		logic [PG_W-1:0] run_j;
		res      = '0;
		all_free = 1'b1;
		tail     = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			pg   = pg0 + PG_W'(j);
			used = word[j] || (pg == '0) || (pg >= cnt);
			if (used) begin
				all_free = 1'b0;
				tail     = '0;
			end else begin
				tail = tail + 1'b1;
			end
			// run length ending at this page, continued from earlier words
			run_j = all_free ? (run_in + PG_W'(j + 1)) : PG_W'(tail);
			if (!res.found && !used && (run_j >= PG_W'(req))) begin
				res.found  = 1'b1;
				res.hit_pg = pg;
			end
			res.run = run_j;
		end
	end

endmodule
